// ===== rtl/c8cpu_pkg.sv =====
// package: shared types and constants for the chip8 processor core
`timescale 1ns / 1ps
`default_nettype none
package c8cpu_pkg;

   // command codes
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_EXEC = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam logic [11:0] PC_START  = 12'h200;
   localparam logic [11:0] FONT_BYTES = 12'd80;

   // request payload
   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] load_addr;
      logic [7:0]  load_byte;
      logic [4:0]  row_index;
      logic [15:0] keys_down;
      logic [7:0]  random_byte;
   } req_type;

   // response payload
   typedef struct packed {
      logic [11:0] next_pc;
      logic [15:0] fetched_opcode;
      logic        sound_on;
      logic        waiting_for_key;
      logic        screen_changed;
      logic        unknown_op;
      logic        stack_fault;
      logic [63:0] row_pixels;
   } rsp_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_INIT,      // memory and frame clearing pass
      ST_IDLE,
      ST_FETCH_HI,
      ST_FETCH_LO,
      ST_DECODE,
      ST_EXEC,
      ST_DRAW_RD,   // read sprite byte
      ST_DRAW_ROW,  // read frame row
      ST_DRAW_WR,   // write frame row
      ST_BCD,
      ST_MOVE,      // fx55 / fx65 walk
      ST_MOVE_WB,
      ST_CLS,
      ST_ROW_RD,
      ST_ROW_WAIT,
      ST_STK_RD,
      ST_FINISH,
      ST_RESP
   } state_type;

   // hex font rom
   function automatic logic [7:0] font_byte(input logic [6:0] a);
      logic [7:0] r;
      begin
         case (a)
            7'd0: r=8'hF0; 7'd1: r=8'h90; 7'd2: r=8'h90; 7'd3: r=8'h90; 7'd4: r=8'hF0;
            7'd5: r=8'h20; 7'd6: r=8'h60; 7'd7: r=8'h20; 7'd8: r=8'h20; 7'd9: r=8'h70;
            7'd10: r=8'hF0; 7'd11: r=8'h10; 7'd12: r=8'hF0; 7'd13: r=8'h80; 7'd14: r=8'hF0;
            7'd15: r=8'hF0; 7'd16: r=8'h10; 7'd17: r=8'hF0; 7'd18: r=8'h10; 7'd19: r=8'hF0;
            7'd20: r=8'h90; 7'd21: r=8'h90; 7'd22: r=8'hF0; 7'd23: r=8'h10; 7'd24: r=8'h10;
            7'd25: r=8'hF0; 7'd26: r=8'h80; 7'd27: r=8'hF0; 7'd28: r=8'h10; 7'd29: r=8'hF0;
            7'd30: r=8'hF0; 7'd31: r=8'h80; 7'd32: r=8'hF0; 7'd33: r=8'h90; 7'd34: r=8'hF0;
            7'd35: r=8'hF0; 7'd36: r=8'h10; 7'd37: r=8'h20; 7'd38: r=8'h40; 7'd39: r=8'h40;
            7'd40: r=8'hF0; 7'd41: r=8'h90; 7'd42: r=8'hF0; 7'd43: r=8'h90; 7'd44: r=8'hF0;
            7'd45: r=8'hF0; 7'd46: r=8'h90; 7'd47: r=8'hF0; 7'd48: r=8'h10; 7'd49: r=8'hF0;
            7'd50: r=8'hF0; 7'd51: r=8'h90; 7'd52: r=8'hF0; 7'd53: r=8'h90; 7'd54: r=8'h90;
            7'd55: r=8'hE0; 7'd56: r=8'h90; 7'd57: r=8'hE0; 7'd58: r=8'h90; 7'd59: r=8'hE0;
            7'd60: r=8'hF0; 7'd61: r=8'h80; 7'd62: r=8'h80; 7'd63: r=8'h80; 7'd64: r=8'hF0;
            7'd65: r=8'hE0; 7'd66: r=8'h90; 7'd67: r=8'h90; 7'd68: r=8'h90; 7'd69: r=8'hE0;
            7'd70: r=8'hF0; 7'd71: r=8'h80; 7'd72: r=8'hF0; 7'd73: r=8'h80; 7'd74: r=8'hF0;
            7'd75: r=8'hF0; 7'd76: r=8'h80; 7'd77: r=8'hF0; 7'd78: r=8'h80; 7'd79: r=8'h80;
            default: r = 8'h00;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/c8cpu_if.sv =====
// interface: valid/ready channel carrying one payload
`timescale 1ns / 1ps
`default_nettype none
interface c8cpu_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/c8cpu_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module c8cpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// ===== rtl/c8cpu_alu.sv =====
// shared alu: 8-bit ops and 12-bit address add, one per cycle
`timescale 1ns / 1ps
`default_nettype none
module c8cpu_alu
   import c8cpu_pkg::*;
(
   input  wire logic [3:0]  func,
   input  wire logic [11:0] a,
   input  wire logic [11:0] b,
   output logic      [11:0] result,
   output logic             flag
);
   logic [12:0] sum;
   logic [8:0]  d;

   // function select: 0 add12, 1 or, 2 and, 3 xor, 4 add8, 5 a-b, 6 shr, 7 b-a, 8 shl
   always_comb begin
      sum    = {1'b0, a} + {1'b0, b};
      d      = 9'd0;
      result = 12'd0;
      flag   = 1'b0;
      case (func)
         4'd0: begin result = sum[11:0]; flag = sum[12]; end
         4'd1: result = {4'd0, a[7:0] | b[7:0]};
         4'd2: result = {4'd0, a[7:0] & b[7:0]};
         4'd3: result = {4'd0, a[7:0] ^ b[7:0]};
         4'd4: begin d = {1'b0, a[7:0]} + {1'b0, b[7:0]}; result = {4'd0, d[7:0]}; flag = d[8]; end
         4'd5: begin d = {1'b0, a[7:0]} - {1'b0, b[7:0]}; result = {4'd0, d[7:0]}; flag = ~d[8]; end
         4'd6: begin result = {5'd0, a[7:1]}; flag = a[0]; end
         4'd7: begin d = {1'b0, b[7:0]} - {1'b0, a[7:0]}; result = {4'd0, d[7:0]}; flag = ~d[8]; end
         4'd8: begin result = {4'd0, a[6:0], 1'b0}; flag = a[7]; end
         default: result = 12'd0;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/chip8_cpu_core_top.sv =====
// top level: chip8 processor core with multi-cycle sequencer
//
//  channel | dir | payload
//  req     | in  | cmd, load_addr, load_byte, row_index, keys_down, random_byte
//  rsp     | out | next_pc, fetched_opcode, flags, row_pixels
//
// after reset a clearing pass over all 4096 memory bytes loads the font and zeroes the
// frame; no transaction is accepted meanwhile.
// every transaction passes through the response step and then returns to idle.
// all main memory traffic goes through its single port; frame and stack have their own rams.
// the response waits in its register until taken while the next transaction
// runs; the core holds in its response step only while that register is full.
`timescale 1ns / 1ps
`default_nettype none
module chip8_cpu_core_top
   import c8cpu_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   c8cpu_if.sink    req,
   c8cpu_if.source  rsp
);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int SAW = $clog2(STACK_DEPTH);

   req_type   req_d;
   rsp_type   rsp_d;
   assign req_d = req_type'(req.data);
   assign rsp.data = rsp_d;

   state_type state_ff, state_in;
   req_type   cur_ff, cur_in;
   logic [11:0] pc_ff, pc_in, npc_ff, npc_in, i_ff, i_in;
   logic [15:0] op_ff, op_in;
   logic [7:0]  v_ff [16];
   logic [7:0]  v_in [16];
   logic [SPW-1:0] sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in;
   logic [11:0] cnt_ff, cnt_in;
   logic [7:0]  byte_ff, byte_in;
   logic        hit_ff, hit_in, chg_ff, chg_in, wait_ff, wait_in;
   logic        unk_ff, unk_in, sf_ff, sf_in;
   logic [63:0] row_ff, row_in;
   rsp_type     out_ff, out_in;
   logic        rv_ff, rv_in;

   // main memory port
   logic        m_we;
   logic [11:0] m_addr;
   logic [7:0]  m_wd, m_rd;
   c8cpu_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
      .clock(clock), .wr_en(m_we), .addr(m_addr), .wr_data(m_wd), .rd_data(m_rd));

   // frame memory port
   logic        f_we;
   logic [4:0]  f_addr;
   logic [63:0] f_wd, f_rd;
   c8cpu_ram #(.WIDTH(64), .DEPTH(32)) u_frame (
      .clock(clock), .wr_en(f_we), .addr(f_addr), .wr_data(f_wd), .rd_data(f_rd));

   // return stack
   logic           s_we;
   logic [SAW-1:0] s_addr;
   logic [11:0]    s_wd, s_rd;
   c8cpu_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(s_we), .addr(s_addr), .wr_data(s_wd), .rd_data(s_rd));

   // shared alu
   logic [3:0]  a_func;
   logic [11:0] a_a, a_b, a_r;
   logic        a_f;
   c8cpu_alu u_alu (.func(a_func), .a(a_a), .b(a_b), .result(a_r), .flag(a_f));

   logic [3:0]  ox, oy, on;
   logic [7:0]  onn, vx, vy;
   logic [5:0]  cx;
   logic [4:0]  cy;
   logic [63:0] line;
   logic [127:0] wide;
   assign ox  = op_ff[11:8];
   assign oy  = op_ff[7:4];
   assign on  = op_ff[3:0];
   assign onn = op_ff[7:0];
   assign vx  = v_ff[ox];
   assign vy  = v_ff[oy];
   assign cx  = vx[5:0];
   assign cy  = vy[4:0];
   assign wide = {byte_ff, 56'd0, 64'd0} >> cx;
   assign line = wide[127:64] | wide[63:0];

   // decimal digits by compare and subtract
   logic [1:0] bcd_h;
   logic [7:0] bcd_sub;
   logic [6:0] bcd_r, bcd_tx10;
   logic [3:0] bcd_t, bcd_o;
   assign bcd_h = (byte_ff >= 8'd200) ? 2'd2 : (byte_ff >= 8'd100) ? 2'd1 : 2'd0;
   assign bcd_sub = (bcd_h == 2'd2) ? 8'd200 : (bcd_h == 2'd1) ? 8'd100 : 8'd0;
   assign bcd_r = 7'(byte_ff - bcd_sub);
   assign bcd_t = (bcd_r >= 7'd90) ? 4'd9 : (bcd_r >= 7'd80) ? 4'd8 :
                  (bcd_r >= 7'd70) ? 4'd7 : (bcd_r >= 7'd60) ? 4'd6 :
                  (bcd_r >= 7'd50) ? 4'd5 : (bcd_r >= 7'd40) ? 4'd4 :
                  (bcd_r >= 7'd30) ? 4'd3 : (bcd_r >= 7'd20) ? 4'd2 :
                  (bcd_r >= 7'd10) ? 4'd1 : 4'd0;
   assign bcd_tx10 = {bcd_t, 3'd0} + {2'd0, bcd_t, 1'b0};
   assign bcd_o = bcd_r[3:0] - bcd_tx10[3:0];

   // state register and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         pc_ff    <= PC_START;
         i_ff     <= 12'd0;
         sp_ff    <= '0;
         dt_ff    <= 8'd0;
         st_ff    <= 8'd0;
         cnt_ff   <= 12'd0;
         rv_ff    <= 1'b0;
         for (int k = 0; k < 16; k++) v_ff[k] <= 8'd0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         i_ff     <= i_in;
         sp_ff    <= sp_in;
         dt_ff    <= dt_in;
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
         for (int k = 0; k < 16; k++) v_ff[k] <= v_in[k];
      end
      cur_ff  <= cur_in;
      npc_ff  <= npc_in;
      op_ff   <= op_in;
      byte_ff <= byte_in;
      hit_ff  <= hit_in;
      chg_ff  <= chg_in;
      wait_ff <= wait_in;
      unk_ff  <= unk_in;
      sf_ff   <= sf_in;
      row_ff  <= row_in;
      out_ff  <= out_in;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp_d     = out_ff;

   // sequencer: next state, memory ports, alu
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff; pc_in = pc_ff; npc_in = npc_ff; i_in = i_ff; op_in = op_ff;
      for (int k = 0; k < 16; k++) v_in[k] = v_ff[k];
      sp_in = sp_ff; dt_in = dt_ff; st_in = st_ff; cnt_in = cnt_ff;
      byte_in = byte_ff; hit_in = hit_ff; chg_in = chg_ff; wait_in = wait_ff;
      unk_in = unk_ff; sf_in = sf_ff; row_in = row_ff; out_in = out_ff; rv_in = rv_ff;
      m_we = 1'b0; m_addr = cnt_ff; m_wd = 8'd0;
      f_we = 1'b0; f_addr = cnt_ff[4:0]; f_wd = 64'd0;
      s_we = 1'b0; s_addr = '0; s_wd = pc_ff;
      a_func = 4'd0; a_a = i_ff; a_b = cnt_ff;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         ST_INIT: begin
            m_we = 1'b1;
            m_wd = (cnt_ff < FONT_BYTES) ? font_byte(cnt_ff[6:0]) : 8'd0;
            f_we = 1'b1;
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff == 12'hFFF) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req.valid) begin
               cur_in = req_d;
               op_in = 16'd0; wait_in = 1'b0; chg_in = 1'b0; unk_in = 1'b0;
               sf_in = 1'b0; row_in = 64'd0; hit_in = 1'b0; cnt_in = 12'd0;
               case (req_d.cmd)
                  CMD_LOAD: begin
                     m_we = 1'b1; m_addr = req_d.load_addr; m_wd = req_d.load_byte;
                     state_in = ST_RESP;
                  end
                  CMD_EXEC: state_in = ST_FETCH_HI;
                  CMD_READ: state_in = ST_ROW_RD;
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_ROW_RD: begin
            f_addr = cur_ff.row_index; state_in = ST_ROW_WAIT;
         end
         ST_ROW_WAIT: begin
            row_in = f_rd; state_in = ST_RESP;
         end
         ST_FETCH_HI: begin
            m_addr = pc_ff; state_in = ST_FETCH_LO;
         end
         ST_FETCH_LO: begin
            m_addr = pc_ff + 12'd1; op_in[15:8] = m_rd; state_in = ST_DECODE;
         end
         ST_DECODE: begin
            op_in[7:0] = m_rd;
            npc_in = pc_ff + 12'd2;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == 16'h00E0) begin
                     chg_in = 1'b1; cnt_in = 12'd0; state_in = ST_CLS;
                  end else if (op_ff == 16'h00EE) begin
                     if (sp_ff == '0) sf_in = 1'b1;
                     else begin
                        s_addr = SAW'(sp_ff - SPW'(1));
                        sp_in = sp_ff - SPW'(1);
                        state_in = ST_STK_RD;
                     end
                  end else unk_in = 1'b1;
               end
               4'h1: npc_in = op_ff[11:0];
               4'h2: begin
                  if (sp_ff >= SPW'(STACK_DEPTH)) sf_in = 1'b1;
                  else begin
                     s_we = 1'b1; s_addr = SAW'(sp_ff); s_wd = pc_ff;
                     sp_in = sp_ff + SPW'(1); npc_in = op_ff[11:0];
                  end
               end
               4'h3: if (vx == onn) npc_in = npc_ff + 12'd2;
               4'h4: if (vx != onn) npc_in = npc_ff + 12'd2;
               4'h5: if (vx == vy) npc_in = npc_ff + 12'd2;
               4'h6: v_in[ox] = onn;
               4'h7: begin
                  a_func = 4'd4; a_a = {4'd0, vx}; a_b = {4'd0, onn}; v_in[ox] = a_r[7:0];
               end
               4'h8: begin
                  a_a = {4'd0, vx}; a_b = {4'd0, vy};
                  case (on)
                     4'h0: v_in[ox] = vy;
                     4'h1, 4'h2, 4'h3: begin a_func = on; v_in[ox] = a_r[7:0]; end
                     4'h4, 4'h5, 4'h6, 4'h7: begin
                        a_func = on; v_in[ox] = a_r[7:0]; v_in[15] = {7'd0, a_f};
                     end
                     4'hE: begin a_func = 4'd8; v_in[ox] = a_r[7:0]; v_in[15] = {7'd0, a_f}; end
                     default: unk_in = 1'b1;
                  endcase
               end
               4'h9: if (vx != vy) npc_in = npc_ff + 12'd2;
               4'hA: i_in = op_ff[11:0];
               4'hB: begin
                  a_func = 4'd0; a_a = op_ff[11:0]; a_b = {4'd0, v_ff[0]}; npc_in = a_r;
               end
               4'hC: v_in[ox] = cur_ff.random_byte & onn;
               4'hD: begin
                  cnt_in = 12'd0;
                  if (on != 4'd0) state_in = ST_DRAW_RD;
                  else v_in[15] = 8'd0;
               end
               4'hE: begin
                  if (onn == 8'h9E) begin
                     if (vx < 8'd16 && cur_ff.keys_down[vx[3:0]]) npc_in = npc_ff + 12'd2;
                  end else if (onn == 8'hA1) begin
                     if (!(vx < 8'd16 && cur_ff.keys_down[vx[3:0]]))
                        npc_in = npc_ff + 12'd2;
                  end else unk_in = 1'b1;
               end
               default: begin
                  case (onn)
                     8'h07: v_in[ox] = dt_ff;
                     8'h0A: begin
                        if (cur_ff.keys_down == 16'd0) begin
                           wait_in = 1'b1; npc_in = pc_ff;
                        end else begin
                           for (int k = 0; k < 16; k++)
                              if (cur_ff.keys_down[k]) v_in[ox] = 8'(k);
                        end
                     end
                     8'h15: dt_in = vx;
                     8'h18: st_in = vx;
                     8'h1E: begin
                        a_func = 4'd0; a_a = i_ff; a_b = {4'd0, vx};
                        i_in = a_r; v_in[15] = {7'd0, a_f};
                     end
                     8'h29: begin
                        a_func = 4'd0; a_a = {2'd0, vx, 2'd0}; a_b = {4'd0, vx}; i_in = a_r;
                     end
                     8'h33: begin
                        cnt_in = 12'd0; byte_in = vx; state_in = ST_BCD;
                     end
                     8'h55, 8'h65: begin cnt_in = 12'd0; state_in = ST_MOVE; end
                     default: unk_in = 1'b1;
                  endcase
               end
            endcase
         end
         ST_STK_RD: begin
            s_addr = SAW'(sp_ff);
            state_in = ST_MOVE_WB;
         end
         ST_CLS: begin
            f_we = 1'b1; f_addr = cnt_ff[4:0];
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff[4:0] == 5'd31) state_in = ST_FINISH;
         end
         ST_DRAW_RD: begin
            a_func = 4'd0; a_a = i_ff; a_b = cnt_ff; m_addr = a_r;
            state_in = ST_DRAW_ROW;
         end
         ST_DRAW_ROW: begin
            byte_in = m_rd;
            f_addr = cy + cnt_ff[4:0];
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            f_addr = cy + cnt_ff[4:0];
            f_we = 1'b1; f_wd = f_rd ^ line;
            if (line != 64'd0) chg_in = 1'b1;
            if ((f_rd & line) != 64'd0) hit_in = 1'b1;
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff[3:0] + 4'd1 == on) begin
               v_in[15] = {7'd0, hit_ff | ((f_rd & line) != 64'd0)};
               state_in = ST_FINISH;
            end else state_in = ST_DRAW_RD;
         end
         ST_BCD: begin
            a_func = 4'd0; a_a = i_ff; a_b = cnt_ff; m_addr = a_r; m_we = 1'b1;
            case (cnt_ff[1:0])
               2'd0: m_wd = {6'd0, bcd_h};
               2'd1: m_wd = {4'd0, bcd_t};
               default: m_wd = {4'd0, bcd_o};
            endcase
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff[1:0] == 2'd2) state_in = ST_FINISH;
         end
         ST_MOVE: begin
            a_func = 4'd0; a_a = i_ff; a_b = cnt_ff; m_addr = a_r;
            if (onn == 8'h55) begin
               m_we = 1'b1; m_wd = v_ff[cnt_ff[3:0]];
               cnt_in = cnt_ff + 12'd1;
               if (cnt_ff[3:0] == ox) begin
                  i_in = a_r + 12'd1; state_in = ST_FINISH;
               end
            end else state_in = ST_MOVE_WB;
         end
         ST_MOVE_WB: begin
            if (op_ff == 16'h00EE) begin
               npc_in = s_rd + 12'd2; state_in = ST_FINISH;
            end else begin
               v_in[cnt_ff[3:0]] = m_rd;
               cnt_in = cnt_ff + 12'd1;
               if (cnt_ff[3:0] == ox) begin
                  a_func = 4'd0; a_a = i_ff; a_b = cnt_ff;
                  i_in = a_r + 12'd1; state_in = ST_FINISH;
               end else state_in = ST_MOVE;
            end
         end
         ST_FINISH: begin
            pc_in = npc_ff;
            if (dt_ff != 8'd0) dt_in = dt_ff - 8'd1;
            if (st_ff != 8'd0) st_in = st_ff - 8'd1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // hand over only once the response register is free
            if (!rv_ff || rsp.ready) begin
               out_in.next_pc = pc_ff;
               out_in.fetched_opcode = op_ff;
               out_in.sound_on = (st_ff != 8'd0);
               out_in.waiting_for_key = wait_ff;
               out_in.screen_changed = chg_ff;
               out_in.unknown_op = unk_ff;
               out_in.stack_fault = sf_ff;
               out_in.row_pixels = row_ff;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // checks
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH)) else $error("stack pointer out of range");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp.ready) |=> rv_ff) else $error("response dropped");
   a_resp_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |=> rv_ff) else $error("response lost");
endmodule
`default_nettype wire

// ===== dv/tb_chip8_checker.sv =====
// checker: watches both channels, predicts every response and compares it
`timescale 1ns / 1ps
module tb_chip8_checker
   import c8cpu_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int          fail_count,
   output int          pending,
   output logic [11:0] model_pc
);

   localparam logic [7:0] HEX_GLYPHS [80] = '{
      8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
      8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
      8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
      8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
      8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
      8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
      8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
      8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
   };

   // shadow copy of the processor state
   logic [7:0]  ram [4096];
   logic [7:0]  vreg [16];
   logic [11:0] ireg;
   logic [11:0] pc;
   logic [11:0] call_stack [STACK_DEPTH];
   int unsigned sp;
   logic [7:0]  delay_tmr;
   logic [7:0]  sound_tmr;
   logic [63:0] frame [32];
   rsp_type     expected_rsp_q [$];

   initial begin
      fail_count = 0;
      pending = 0;
      model_pc = 12'h000;
   end

   task automatic clear_state();
      begin
         for (int k = 0; k < 4096; k++) ram[k] = (k < 80) ? HEX_GLYPHS[k] : 8'h00;
         for (int k = 0; k < 16; k++) vreg[k] = 8'h00;
         for (int k = 0; k < STACK_DEPTH; k++) call_stack[k] = 12'h000;
         for (int k = 0; k < 32; k++) frame[k] = 64'h0;
         ireg = 12'h000;
         pc = PC_START;
         sp = 0;
         delay_tmr = 8'h00;
         sound_tmr = 8'h00;
      end
   endtask

   // one instruction: fetch, decode, execute, then the timers
   function automatic rsp_type exec_cycle(input logic [15:0] keys, input logic [7:0] rnd);
      rsp_type     res;
      logic [15:0] op;
      logic [11:0] npc, nnn;
      logic [3:0]  x, y, n;
      logic [7:0]  nn, vx, vy, r, f;
      logic [63:0] line;
      logic [4:0]  ry;
      logic [5:0]  cx;
      logic [12:0] s;
      bit          alu, hit;
      begin
         res = '0;
         alu = 0;
         hit = 0;
         r = 8'h00;
         f = 8'h00;
         op = {ram[pc], ram[pc + 12'd1]};
         x = op[11:8];
         y = op[7:4];
         n = op[3:0];
         nn = op[7:0];
         nnn = op[11:0];
         vx = vreg[x];
         vy = vreg[y];
         npc = pc + 12'd2;
         case (op[15:12])
            4'h0: begin
               if (op == 16'h00E0) begin
                  for (int k = 0; k < 32; k++) frame[k] = 64'h0;
                  res.screen_changed = 1'b1;
               end else if (op == 16'h00EE) begin
                  // return on an empty stack faults and falls through
                  if (sp == 0) res.stack_fault = 1'b1;
                  else begin
                     sp--;
                     npc = call_stack[sp] + 12'd2;
                  end
               end else res.unknown_op = 1'b1;
            end
            4'h1: npc = nnn;
            4'h2: begin
               // call on a full stack faults, nothing pushed
               if (sp >= STACK_DEPTH) res.stack_fault = 1'b1;
               else begin
                  call_stack[sp] = pc;
                  sp++;
                  npc = nnn;
               end
            end
            4'h3: if (vx == nn) npc = npc + 12'd2;
            4'h4: if (vx != nn) npc = npc + 12'd2;
            4'h5: if (vx == vy) npc = npc + 12'd2;
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = vx + nn;
            4'h8: begin
               case (n)
                  4'h0: vreg[x] = vy;
                  4'h1: vreg[x] = vx | vy;
                  4'h2: vreg[x] = vx & vy;
                  4'h3: vreg[x] = vx ^ vy;
                  4'h4: begin
                     r = vx + vy; f = {7'd0, ({1'b0, vx} + {1'b0, vy} > 9'd255)}; alu = 1;
                  end
                  4'h5: begin r = vx - vy; f = {7'd0, (vx >= vy)}; alu = 1; end
                  4'h6: begin r = vx >> 1; f = {7'd0, vx[0]}; alu = 1; end
                  4'h7: begin r = vy - vx; f = {7'd0, (vy >= vx)}; alu = 1; end
                  4'hE: begin r = vx << 1; f = {7'd0, vx[7]}; alu = 1; end
                  default: res.unknown_op = 1'b1;
               endcase
               // flag lands after the result
               if (alu) begin
                  vreg[x] = r;
                  vreg[15] = f;
               end
            end
            4'h9: if (vx != vy) npc = npc + 12'd2;
            4'hA: ireg = nnn;
            4'hB: npc = nnn + {4'h0, vreg[0]};
            4'hC: vreg[x] = rnd & nn;
            4'hD: begin
               // sprite rows xor into the frame, wrapping on both axes
               cx = vx[5:0];
               for (int k = 0; k < n; k++) begin
                  line = {ram[ireg + k[11:0]], 56'h0};
                  ry = vy[4:0] + k[4:0];
                  if (cx != 0) line = (line >> cx) | (line << (7'd64 - cx));
                  if (line != 64'h0) res.screen_changed = 1'b1;
                  if ((frame[ry] & line) != 64'h0) hit = 1;
                  frame[ry] = frame[ry] ^ line;
               end
               vreg[15] = {7'd0, hit};
            end
            4'hE: begin
               if (nn == 8'h9E) begin
                  if (vx < 16 && keys[vx[3:0]]) npc = npc + 12'd2;
               end else if (nn == 8'hA1) begin
                  if (!(vx < 16 && keys[vx[3:0]])) npc = npc + 12'd2;
               end else res.unknown_op = 1'b1;
            end
            default: begin
               case (nn)
                  8'h07: vreg[x] = delay_tmr;
                  8'h0A: begin
                     // stall in place until a key is down, highest key wins
                     if (keys == 16'h0) begin
                        res.waiting_for_key = 1'b1;
                        npc = pc;
                     end else
                        for (int k = 0; k < 16; k++) if (keys[k]) vreg[x] = k[7:0];
                  end
                  8'h15: delay_tmr = vx;
                  8'h18: sound_tmr = vx;
                  8'h1E: begin
                     s = {1'b0, ireg} + {5'd0, vx};
                     ireg = s[11:0];
                     vreg[15] = {7'd0, s[12]};
                  end
                  8'h29: ireg = {4'h0, vx} * 12'd5;
                  8'h33: begin
                     ram[ireg] = vx / 8'd100;
                     ram[ireg + 12'd1] = (vx % 8'd100) / 8'd10;
                     ram[ireg + 12'd2] = vx % 8'd10;
                  end
                  8'h55: begin
                     for (int k = 0; k <= x; k++) ram[ireg + k[11:0]] = vreg[k];
                     ireg = ireg + {8'h0, x} + 12'd1;
                  end
                  8'h65: begin
                     for (int k = 0; k <= x; k++) vreg[k] = ram[ireg + k[11:0]];
                     ireg = ireg + {8'h0, x} + 12'd1;
                  end
                  default: res.unknown_op = 1'b1;
               endcase
            end
         endcase
         pc = npc;
         if (delay_tmr != 0) delay_tmr--;
         if (sound_tmr != 0) sound_tmr--;
         res.fetched_opcode = op;
         return res;
      end
   endfunction

   function automatic rsp_type predict_response(input req_type rq);
      rsp_type res;
      begin
         res = '0;
         case (rq.cmd)
            CMD_LOAD: ram[rq.load_addr] = rq.load_byte;
            CMD_EXEC: res = exec_cycle(rq.keys_down, rq.random_byte);
            CMD_READ: res.row_pixels = frame[rq.row_index];
            default: ;
         endcase
         res.next_pc = pc;
         res.sound_on = (sound_tmr != 0);
         return res;
      end
   endfunction

   task automatic check_field(input string fname, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      begin
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, fname, exp_v, act_v);
            fail_count++;
         end
      end
   endtask

   // compare taken responses, then predict for accepted requests
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         clear_state();
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response with none expected, actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               check_field("next_pc", exp_rsp.next_pc, rsp_data.next_pc);
               check_field("fetched_opcode", exp_rsp.fetched_opcode, rsp_data.fetched_opcode);
               check_field("sound_on", exp_rsp.sound_on, rsp_data.sound_on);
               check_field("waiting_for_key", exp_rsp.waiting_for_key,
                           rsp_data.waiting_for_key);
               check_field("screen_changed", exp_rsp.screen_changed, rsp_data.screen_changed);
               check_field("unknown_op", exp_rsp.unknown_op, rsp_data.unknown_op);
               check_field("stack_fault", exp_rsp.stack_fault, rsp_data.stack_fault);
               check_field("row_pixels", exp_rsp.row_pixels, rsp_data.row_pixels);
            end
         end
         if (req_valid && req_ready) expected_rsp_q.push_back(predict_response(req_data));
      end
      pending <= expected_rsp_q.size();
      model_pc <= pc;
   end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: clock, reset, request stimulus, response stalls and verdict
`timescale 1ns / 1ps
module tb_top;
   import c8cpu_pkg::*;

   localparam int TARGET_ITEMS = 1700;
   localparam int LONG_HOLD_CYCLES = 400;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   logic [11:0] model_pc;
   int   issued;
   int   burst_left;
   bit   long_hold_req;

   c8cpu_if #(.WIDTH($bits(req_type))) req_ch ();
   c8cpu_if #(.WIDTH($bits(rsp_type))) rsp_ch ();

   chip8_cpu_core_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   tb_chip8_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_data   (req_type'(req_ch.data)),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_data   (rsp_type'(rsp_ch.data)),
      .fail_count (fail_count),
      .pending    (pending),
      .model_pc   (model_pc)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   initial begin
      #60_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int mode;
      int len;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         len = $urandom_range(5, 60);
         for (int k = 0; k < len; k++) begin
            if (long_hold_req) begin
               rsp_ch.ready <= 1'b0;
               repeat (LONG_HOLD_CYCLES) @(posedge clock);
               long_hold_req = 1'b0;
            end
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // offer one transaction and hold until taken; gaps between bursts
   task automatic send(input req_type rq);
      begin
         req_ch.valid <= 1'b1;
         req_ch.data <= rq;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         issued++;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
               req_ch.valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end else burst_left--;
      end
   endtask

   task automatic wait_drained();
      begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (pending != 0) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_keys();
      case ($urandom_range(0, 3))
         0: return 16'h0;
         1: return 16'h1 << $urandom_range(0, 15);
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic req_type make_req(input logic [1:0] cmd, input logic [11:0] addr,
                                        input logic [7:0] data);
      req_type rq;
      begin
         rq.cmd = cmd;
         rq.load_addr = addr;
         rq.load_byte = data;
         rq.row_index = 5'($urandom_range(0, 31));
         rq.keys_down = pick_keys();
         rq.random_byte = 8'($urandom_range(0, 255));
         return rq;
      end
   endfunction

   task automatic load_word(input logic [11:0] addr, input logic [15:0] word);
      begin
         send(make_req(CMD_LOAD, addr, word[15:8]));
         send(make_req(CMD_LOAD, addr + 12'd1, word[7:0]));
      end
   endtask

   // random instruction, weighted toward decoded forms
   function automatic logic [15:0] make_op();
      logic [15:0] op;
      logic [7:0]  f_lows [9];
      begin
         f_lows = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
         op = 16'($urandom_range(0, 16'hFFFF));
         case (op[15:12])
            4'h0: case ($urandom_range(0, 5))
                     0: op = 16'h00E0;
                     1, 2, 3: op = 16'h00EE;
                     default: ;
                  endcase
            4'hD: op[3:0] = 4'($urandom_range(0, 6));
            4'hE: if ($urandom_range(0, 5) != 0)
                     op[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
            4'hF: if ($urandom_range(0, 7) != 0) op[7:0] = f_lows[$urandom_range(0, 8)];
            default: ;
         endcase
         return op;
      end
   endfunction

   initial begin
      req_type     rq;
      logic [11:0] base;
      logic [15:0] words [8];
      int          prog_len;
      int          runs;
      int          phase;
      issued = 0;
      burst_left = 0;
      long_hold_req = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: carry, empty-stack return, index overflow, wrapped draw,
      // fetch at the top of memory, row extremes, reserved command
      words = '{16'h60FF, 16'h8004, 16'h00EE, 16'hAFFF, 16'hF01E, 16'hD015,
                16'h1FFE, 16'h0000};
      for (int k = 0; k < 7; k++) load_word(PC_START + 12'(2 * k), words[k]);
      load_word(12'hFFE, 16'h1200);
      for (int k = 0; k < 8; k++) send(make_req(CMD_EXEC, 12'h000, 8'h00));
      rq = make_req(CMD_READ, 12'h000, 8'h00);
      rq.row_index = 5'd0;
      send(rq);
      rq.row_index = 5'd31;
      send(rq);
      send(make_req(CMD_NONE, 12'hFFF, 8'hFF));

      // random programs written at the current program counter, then run
      phase = 0;
      while (issued < TARGET_ITEMS) begin
         wait_drained();
         base = model_pc;
         phase++;
         if (phase == 4) long_hold_req = 1'b1;
         prog_len = $urandom_range(3, 12);
         for (int k = 0; k < prog_len; k++) load_word(base + 12'(2 * k), make_op());
         runs = $urandom_range(prog_len, 2 * prog_len + 4);
         for (int k = 0; k < runs; k++) begin
            case ($urandom_range(0, 15))
               0, 1: send(make_req(CMD_READ, 12'h000, 8'h00));
               2: send(make_req(CMD_NONE, 12'($urandom_range(0, 12'hFFF)),
                                8'($urandom_range(0, 255))));
               3: send(make_req(CMD_LOAD, 12'($urandom_range(0, 12'hFFF)),
                                8'($urandom_range(0, 255))));
               default: send(make_req(CMD_EXEC, 12'h000, 8'h00));
            endcase
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
